// ===== rtl/core/pma_pkg.sv =====
// Package for the paged memory allocator: controller states, request codes
// and fixed field widths. No dependencies.
`default_nettype none
package pma_pkg;

    localparam int SIZE_W = 21;
    localparam int PID_BITS = 4;
    localparam int BYTE_W = 8;

    localparam logic [1:0] REQ_ALLOC = 2'd0;
    localparam logic [1:0] REQ_FREE = 2'd1;
    localparam logic [1:0] REQ_READ = 2'd2;
    localparam logic [1:0] REQ_WRITE = 2'd3;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK,
        ST_ASCAN,
        ST_AEND,
        ST_FRD,
        ST_FEX,
        ST_UNMAP,
        ST_BYTE
    } t_state;

endpackage
`default_nettype wire

// ===== rtl/core/pma_ram.sv =====
// Generic simple dual-port RAM: one write port and one registered read port.
// No dependencies.
`default_nettype none
module pma_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ===== rtl/core/paged_memory_allocator_mmu.sv =====
// Paged memory allocator with per-process page maps and a byte RAM.
// Depends on pma_pkg and pma_ram.
//
// Usage: a request is taken when start is high and busy is low. Its result
// appears in registers on o_status, o_alloc_addr and o_read_data,
// marked by o_done for exactly one cycle; the receiver cannot stall it.
// A request with a bad process id fails in the next cycle. Read and write
// each do a page map lookup, then a byte RAM access. Alloc checks the size
// and the free frame count first; on success the owner RAM is scanned one
// frame per cycle. Free walks the frame chain (dependent owner/next RAM
// reads, states FRD then FEX for each frame), then unmaps the pages.
// The count of free frames is kept in a register.
// After reset a clearing pass writes every entry of the owner, page map,
// break and byte RAMs, one entry per cycle, up to the largest depth of
// these (the byte RAM with default sizes); busy stays high throughout.
`default_nettype none
module paged_memory_allocator_mmu #(
    parameter int NUM_FRAMES = 1024,
    parameter int OFFSET_BITS = 10,
    parameter int ADDR_BITS = 20,
    parameter int MAX_PROCS = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic [1:0]                      i_req_type,
    input  wire logic [pma_pkg::PID_BITS-1:0]    i_pid,
    input  wire logic [pma_pkg::SIZE_W-1:0]      i_alloc_size,
    input  wire logic [ADDR_BITS-1:0]            i_address,
    input  wire logic [pma_pkg::BYTE_W-1:0]      i_write_data,
    output logic                                 o_done,
    output logic                                 o_status,
    output logic [ADDR_BITS-1:0]                 o_alloc_addr,
    output logic [pma_pkg::BYTE_W-1:0]           o_read_data
);

    localparam int FRAME_W = $clog2(NUM_FRAMES);
    localparam int NEXT_W = $clog2(NUM_FRAMES + 1);
    localparam int VP_W = ADDR_BITS - OFFSET_BITS;
    localparam int PID_W = $clog2(MAX_PROCS);
    localparam int MAP_N = MAX_PROCS << VP_W;
    localparam int MAP_AW = PID_W + VP_W;
    localparam int BYTE_N = NUM_FRAMES << OFFSET_BITS;
    localparam int BYTE_AW = FRAME_W + OFFSET_BITS;
    localparam int BRK_W = ADDR_BITS + 1;
    localparam int SW = pma_pkg::SIZE_W;
    localparam int PG_W = SW - OFFSET_BITS + 1;
    localparam int EW = ((ADDR_BITS > SW) ? ADDR_BITS : SW) + 2;
    localparam int CLR_A = (BYTE_N > MAP_N) ? BYTE_N : MAP_N;
    localparam int CLR_N = (CLR_A > MAX_PROCS) ? CLR_A : MAX_PROCS;
    localparam int CLR_W = $clog2(CLR_N);
    localparam int PB = pma_pkg::PID_BITS;
    localparam int DW = pma_pkg::BYTE_W;

    pma_pkg::t_state r_state, n_state;
    logic [CLR_W-1:0] r_clr, n_clr;
    logic [1:0] r_req, n_req;
    logic [PB-1:0] r_pid, n_pid;
    logic [PG_W-1:0] r_pages, n_pages;
    logic [ADDR_BITS-1:0] r_addr, n_addr;
    logic [DW-1:0] r_wdata, n_wdata;
    logic [BRK_W-1:0] r_bp, n_bp, r_end, n_end;
    logic [VP_W-1:0] r_vbase, n_vbase;
    logic [NEXT_W-1:0] r_idx, n_idx, r_taken, n_taken, r_frame, n_frame;
    logic [NEXT_W-1:0] r_steps, n_steps, r_free_cnt, n_free_cnt;
    logic r_pv, n_pv, r_have_prev, n_have_prev;
    logic [FRAME_W-1:0] r_pidx, n_pidx, r_prev, n_prev;
    logic [VP_W:0] r_vp, n_vp;
    logic r_done, n_done, r_status, n_status;
    logic [ADDR_BITS-1:0] r_aaddr, n_aaddr;
    logic [DW-1:0] r_rdata, n_rdata;

    logic own_we;
    logic [FRAME_W-1:0] own_waddr, own_raddr;
    logic [PB-1:0] own_wdata, own_rd;
    logic nxt_we;
    logic [FRAME_W-1:0] nxt_waddr, nxt_raddr;
    logic [NEXT_W-1:0] nxt_wdata, nxt_rd;
    logic map_we;
    logic [MAP_AW-1:0] map_waddr, map_raddr;
    logic [FRAME_W:0] map_wdata, map_rd;
    logic brk_we;
    logic [PID_W-1:0] brk_waddr, brk_raddr;
    logic [BRK_W-1:0] brk_wdata, brk_rd;
    logic byte_we;
    logic [BYTE_AW-1:0] byte_waddr, byte_raddr;
    logic [DW-1:0] byte_wdata, byte_rd;

    logic pid_ok;
    logic [PID_W-1:0] pid_idx;
    logic [SW:0] size_sum;
    logic [EW-1:0] end_w;
    logic [NEXT_W-1:0] taken_inc;
    logic [BYTE_AW-1:0] phys;

    assign pid_ok = (i_pid != '0) && (32'(i_pid) < MAX_PROCS);
    assign pid_idx = PID_W'(r_pid);
    assign size_sum = {1'b0, i_alloc_size} + (SW + 1)'((1 << OFFSET_BITS) - 1);
    assign end_w = EW'(brk_rd) + (EW'(r_pages) << OFFSET_BITS);
    assign taken_inc = r_taken + 1'b1;
    assign phys = {map_rd[FRAME_W-1:0], r_addr[OFFSET_BITS-1:0]};

    pma_ram #(.WIDTH(PB), .DEPTH(NUM_FRAMES)) u_owner (
        .i_clk(i_clk), .i_we(own_we), .i_waddr(own_waddr), .i_wdata(own_wdata),
        .i_raddr(own_raddr), .o_rdata(own_rd)
    );
    pma_ram #(.WIDTH(NEXT_W), .DEPTH(NUM_FRAMES)) u_next (
        .i_clk(i_clk), .i_we(nxt_we), .i_waddr(nxt_waddr), .i_wdata(nxt_wdata),
        .i_raddr(nxt_raddr), .o_rdata(nxt_rd)
    );
    pma_ram #(.WIDTH(FRAME_W + 1), .DEPTH(MAP_N)) u_map (
        .i_clk(i_clk), .i_we(map_we), .i_waddr(map_waddr), .i_wdata(map_wdata),
        .i_raddr(map_raddr), .o_rdata(map_rd)
    );
    pma_ram #(.WIDTH(BRK_W), .DEPTH(MAX_PROCS)) u_brk (
        .i_clk(i_clk), .i_we(brk_we), .i_waddr(brk_waddr), .i_wdata(brk_wdata),
        .i_raddr(brk_raddr), .o_rdata(brk_rd)
    );
    pma_ram #(.WIDTH(DW), .DEPTH(BYTE_N)) u_byte (
        .i_clk(i_clk), .i_we(byte_we), .i_waddr(byte_waddr), .i_wdata(byte_wdata),
        .i_raddr(byte_raddr), .o_rdata(byte_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pma_pkg::ST_CLEAR;
            r_clr <= '0;
            r_free_cnt <= NEXT_W'(NUM_FRAMES);
            r_done <= 1'b0;
            r_pv <= 1'b0;
            r_have_prev <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr <= n_clr;
            r_free_cnt <= n_free_cnt;
            r_done <= n_done;
            r_pv <= n_pv;
            r_have_prev <= n_have_prev;
        end
        r_req <= n_req;
        r_pid <= n_pid;
        r_pages <= n_pages;
        r_addr <= n_addr;
        r_wdata <= n_wdata;
        r_bp <= n_bp;
        r_end <= n_end;
        r_vbase <= n_vbase;
        r_idx <= n_idx;
        r_taken <= n_taken;
        r_frame <= n_frame;
        r_steps <= n_steps;
        r_pidx <= n_pidx;
        r_prev <= n_prev;
        r_vp <= n_vp;
        r_status <= n_status;
        r_aaddr <= n_aaddr;
        r_rdata <= n_rdata;
    end

    always_comb begin
        n_state = r_state;
        n_clr = r_clr;
        n_req = r_req;
        n_pid = r_pid;
        n_pages = r_pages;
        n_addr = r_addr;
        n_wdata = r_wdata;
        n_bp = r_bp;
        n_end = r_end;
        n_vbase = r_vbase;
        n_idx = r_idx;
        n_taken = r_taken;
        n_frame = r_frame;
        n_steps = r_steps;
        n_free_cnt = r_free_cnt;
        n_pv = 1'b0;
        n_have_prev = r_have_prev;
        n_pidx = r_pidx;
        n_prev = r_prev;
        n_vp = r_vp;
        n_done = 1'b0;
        n_status = r_status;
        n_aaddr = r_aaddr;
        n_rdata = r_rdata;

        own_we = 1'b0;
        own_waddr = r_frame[FRAME_W-1:0];
        own_wdata = '0;
        own_raddr = r_frame[FRAME_W-1:0];
        nxt_we = 1'b0;
        nxt_waddr = r_prev;
        nxt_wdata = NEXT_W'(r_pidx);
        nxt_raddr = r_frame[FRAME_W-1:0];
        map_we = 1'b0;
        map_waddr = {pid_idx, r_vp[VP_W-1:0]};
        map_wdata = '0;
        map_raddr = {PID_W'(i_pid), i_address[ADDR_BITS-1:OFFSET_BITS]};
        brk_we = 1'b0;
        brk_waddr = pid_idx;
        brk_wdata = r_end;
        brk_raddr = PID_W'(i_pid);
        byte_we = 1'b0;
        byte_waddr = phys;
        byte_wdata = r_wdata;
        byte_raddr = phys;

        case (r_state)
            pma_pkg::ST_CLEAR: begin
                own_we = 32'(r_clr) < NUM_FRAMES;
                own_waddr = r_clr[FRAME_W-1:0];
                map_we = 32'(r_clr) < MAP_N;
                map_waddr = r_clr[MAP_AW-1:0];
                brk_we = 32'(r_clr) < MAX_PROCS;
                brk_waddr = r_clr[PID_W-1:0];
                brk_wdata = BRK_W'(1) << OFFSET_BITS;
                byte_we = 32'(r_clr) < BYTE_N;
                byte_waddr = r_clr[BYTE_AW-1:0];
                byte_wdata = '0;
                n_clr = r_clr + 1'b1;
                if (r_clr == CLR_W'(CLR_N - 1)) begin
                    n_state = pma_pkg::ST_IDLE;
                end
            end
            pma_pkg::ST_IDLE: begin
                if (start) begin
                    n_req = i_req_type;
                    n_pid = i_pid;
                    n_pages = size_sum[SW:OFFSET_BITS];
                    n_addr = i_address;
                    n_wdata = i_write_data;
                    if (pid_ok) begin
                        n_state = pma_pkg::ST_LOOK;
                    end else begin
                        n_done = 1'b1;
                        n_status = 1'b1;
                        n_aaddr = '0;
                        n_rdata = '0;
                    end
                end
            end
            pma_pkg::ST_LOOK: begin
                n_aaddr = '0;
                n_rdata = '0;
                n_status = 1'b1;
                case (r_req)
                    pma_pkg::REQ_ALLOC: begin
                        if (r_pages == '0 || end_w > (EW'(1) << ADDR_BITS)
                                || r_free_cnt < r_pages) begin
                            n_done = 1'b1;
                            n_state = pma_pkg::ST_IDLE;
                        end else begin
                            n_bp = brk_rd;
                            n_end = end_w[BRK_W-1:0];
                            n_vbase = brk_rd[ADDR_BITS-1:OFFSET_BITS];
                            n_idx = '0;
                            n_taken = '0;
                            n_have_prev = 1'b0;
                            n_state = pma_pkg::ST_ASCAN;
                        end
                    end
                    pma_pkg::REQ_FREE: begin
                        if (map_rd[FRAME_W]) begin
                            n_frame = NEXT_W'(map_rd[FRAME_W-1:0]);
                            n_steps = '0;
                            n_vp = {1'b0, r_addr[ADDR_BITS-1:OFFSET_BITS]};
                            n_state = pma_pkg::ST_FRD;
                        end else begin
                            n_done = 1'b1;
                            n_state = pma_pkg::ST_IDLE;
                        end
                    end
                    pma_pkg::REQ_READ: begin
                        if (map_rd[FRAME_W]) begin
                            n_state = pma_pkg::ST_BYTE;
                        end else begin
                            n_done = 1'b1;
                            n_state = pma_pkg::ST_IDLE;
                        end
                    end
                    default: begin
                        byte_we = map_rd[FRAME_W];
                        n_status = !map_rd[FRAME_W];
                        n_done = 1'b1;
                        n_state = pma_pkg::ST_IDLE;
                    end
                endcase
            end
            pma_pkg::ST_BYTE: begin
                n_rdata = byte_rd;
                n_status = 1'b0;
                n_done = 1'b1;
                n_state = pma_pkg::ST_IDLE;
            end
            pma_pkg::ST_ASCAN: begin
                own_raddr = r_idx[FRAME_W-1:0];
                if (32'(r_idx) < NUM_FRAMES) begin
                    n_idx = r_idx + 1'b1;
                    n_pv = 1'b1;
                    n_pidx = r_idx[FRAME_W-1:0];
                end
                if (r_pv && own_rd == '0) begin
                    own_we = 1'b1;
                    own_waddr = r_pidx;
                    own_wdata = r_pid;
                    nxt_we = r_have_prev;
                    map_we = 1'b1;
                    map_waddr = {pid_idx, VP_W'(r_vbase + VP_W'(r_taken))};
                    map_wdata = {1'b1, r_pidx};
                    n_prev = r_pidx;
                    n_have_prev = 1'b1;
                    n_taken = taken_inc;
                    if (taken_inc == r_pages) begin
                        n_state = pma_pkg::ST_AEND;
                    end
                end
            end
            pma_pkg::ST_AEND: begin
                nxt_we = 1'b1;
                nxt_wdata = NEXT_W'(NUM_FRAMES);
                brk_we = 1'b1;
                n_free_cnt = r_free_cnt - NEXT_W'(r_pages);
                n_aaddr = r_bp[ADDR_BITS-1:0];
                n_status = 1'b0;
                n_done = 1'b1;
                n_state = pma_pkg::ST_IDLE;
            end
            pma_pkg::ST_FRD: begin
                if (32'(r_steps) == NUM_FRAMES || 32'(r_frame) >= NUM_FRAMES) begin
                    n_state = pma_pkg::ST_UNMAP;
                end else begin
                    n_state = pma_pkg::ST_FEX;
                end
            end
            pma_pkg::ST_FEX: begin
                own_we = 1'b1;
                if (own_rd != '0) begin
                    n_free_cnt = r_free_cnt + 1'b1;
                end
                n_frame = nxt_rd;
                n_steps = r_steps + 1'b1;
                n_state = pma_pkg::ST_FRD;
            end
            pma_pkg::ST_UNMAP: begin
                if (r_steps == '0 || r_vp[VP_W]) begin
                    n_status = 1'b0;
                    n_done = 1'b1;
                    n_state = pma_pkg::ST_IDLE;
                end else begin
                    map_we = 1'b1;
                    n_vp = r_vp + 1'b1;
                    n_steps = r_steps - 1'b1;
                end
            end
            default: begin
                n_state = pma_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy = (r_state != pma_pkg::ST_IDLE);
    assign o_done = r_done;
    assign o_status = r_status;
    assign o_alloc_addr = r_aaddr;
    assign o_read_data = r_rdata;

    a_free_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_free_cnt) <= NUM_FRAMES)
        else $error("free frame count exceeds the number of frames");

    a_bad_pid_fails: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !pid_ok) |=> (o_done && o_status))
        else $error("request with a bad process id did not fail at once");

    a_addr_on_success: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_alloc_addr != '0) |-> !o_status)
        else $error("allocation address given with a failure status");

    a_scan_has_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pma_pkg::ST_ASCAN) |-> (r_free_cnt >= r_pages))
        else $error("frame scan started without enough free frames");

endmodule
`default_nettype wire
